// ===== rtl/lld_pkg.sv =====
// Package for the least-loaded dispatcher.
// Holds the action codes, sequencer states and fixed field widths.
// No dependencies.
package lld_pkg;

  localparam int unsigned PeIdWidth   = 4;
  localparam int unsigned PeCntWidth  = 5;
  localparam int unsigned UntilWidth  = 32;
  localparam int unsigned TotalWidth  = 32;
  localparam logic [PeCntWidth-1:0] PeCountReset = 5'd16;

  typedef enum logic [1:0] {
    ACT_SCHEDULE  = 2'd0,
    ACT_MARK_BUSY = 2'd1,
    ACT_MARK_IDLE = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

// ===== rtl/lld_in_if.sv =====
// Input channel of the least-loaded dispatcher: valid/ready plus one request.
// Depends on lld_pkg.
interface lld_in_if;
  logic                                valid;
  logic                                ready;
  lld_pkg::action_e                    action;
  logic [lld_pkg::PeIdWidth-1:0]       pe_id;
  logic [lld_pkg::UntilWidth-1:0]      busy_until;

  modport source (output valid, action, pe_id, busy_until, input ready);
  modport sink   (input valid, action, pe_id, busy_until, output ready);
endinterface

// ===== rtl/lld_out_if.sv =====
// Result channel of the least-loaded dispatcher: valid/ready plus one result.
// Depends on lld_pkg.
interface lld_out_if;
  logic                                valid;
  logic                                ready;
  logic [lld_pkg::PeIdWidth-1:0]       chosen_pe;
  logic                                no_pes;
  logic [lld_pkg::TotalWidth-1:0]      total_scheduled;

  modport source (output valid, chosen_pe, no_pes, total_scheduled, input ready);
  modport sink   (input valid, chosen_pe, no_pes, total_scheduled, output ready);
endinterface

// ===== rtl/least_loaded_dispatcher.sv =====
// Least-loaded dispatcher: top level with per-element counts, busy flags and scan sequencer.
// Depends on lld_pkg, lld_in_if and lld_out_if.
//
// Usage:
//   in_i carries requests (schedule, mark busy, mark idle, clear counts); a transfer
//   happens when valid and ready are both high. out_o carries one result per
//   schedule request: the chosen element, a no-elements flag and the running total.
//   cfg_we_i/cfg_wdata_i write pe_count; write it only while the block is idle.
//   Mark busy, mark idle and clear produce no result, and the block stays ready.
//   A schedule request reads the count memory one element per cycle through a
//   single comparator over N = max(1, min(pe_count, NUM_PES)) elements. The block
//   is not ready from the input transfer until the update step has written the
//   result, so it takes no new request while a schedule is in flight.
//   Results sit in an output register; the block takes new requests while a
//   result waits, but a schedule request holds in its update step until the
//   output register is free.
//   Reset zeroes all counts (through per-entry valid bits), the busy flags and the
//   total, and sets pe_count to 16. No clearing pass is needed.
module least_loaded_dispatcher #(
  parameter int unsigned NUM_PES     = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lld_pkg::PeCntWidth-1:0]     cfg_wdata_i,
  lld_in_if.sink                             in_i,
  lld_out_if.source                          out_o
);

  localparam int unsigned IdxW   = (NUM_PES > 1) ? $clog2(NUM_PES) : 1;
  localparam int unsigned WideW  = (IdxW + 1 > 5) ? IdxW + 1 : 5;
  localparam int unsigned LoadW  = COUNT_WIDTH + 1;
  localparam int unsigned TotExtW = (COUNT_WIDTH > lld_pkg::TotalWidth) ?
                                    COUNT_WIDTH : lld_pkg::TotalWidth;
  localparam int unsigned ScanW  = lld_pkg::PeCntWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  lld_pkg::state_e state_q, state_d;

  logic [ScanW-1:0]       pe_count_q;
  logic [ScanW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [ScanW-1:0]       n_eff_q, n_eff_d;
  logic                   no_pes_q, no_pes_d;
  logic [NUM_PES-1:0]     valid_q;
  logic [NUM_PES-1:0]     busy_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic                   out_valid_q;

  logic [COUNT_WIDTH-1:0] mem [NUM_PES];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_valid_q;
  logic                   rd_busy_q;

  logic [ScanW-1:0]              best_q;
  logic [COUNT_WIDTH-1:0]        best_cnt_q;
  logic                          best_busy_q;

  logic [lld_pkg::PeIdWidth-1:0] out_sel_q;
  logic                          out_no_pes_q;
  logic [lld_pkg::TotalWidth-1:0] out_total_q;

  // Sequencer outputs
  logic                          in_ready;
  logic                          scan_active;
  logic                          upd_fire;
  logic [ScanW-1:0]              rd_idx;

  logic accept, sched_acc, last_cmp, slot_free, take_cur;
  logic [WideW-1:0] pe_cnt_w, num_w, n_w, pe_id_w, rd_idx_w, best_w;
  logic [ScanW-1:0] n_sel;
  logic [IdxW-1:0]  rd_addr, wr_addr, id_addr;
  logic             id_in_range;
  logic [COUNT_WIDTH-1:0] cur_cnt, new_cnt, new_total;
  logic [LoadW-1:0] cur_load, best_load;
  logic [TotExtW-1:0] total_ext;

  assign accept    = in_i.valid && in_ready;
  assign sched_acc = accept && (in_i.action == lld_pkg::ACT_SCHEDULE);
  assign slot_free = !out_valid_q || out_o.ready;
  assign last_cmp  = (cmp_idx_q + ScanW'(1)) == n_eff_q;

  // Clamp pe_count to the element array.
  assign pe_cnt_w = WideW'(pe_count_q);
  assign num_w    = WideW'(NUM_PES);
  assign n_w      = (pe_cnt_w > num_w) ? num_w : pe_cnt_w;
  assign n_sel    = n_w[ScanW-1:0];

  assign pe_id_w     = WideW'(in_i.pe_id);
  assign id_in_range = pe_id_w < num_w;
  assign id_addr     = pe_id_w[IdxW-1:0];
  assign rd_idx_w    = WideW'(rd_idx);
  assign rd_addr     = rd_idx_w[IdxW-1:0];
  assign best_w      = WideW'(best_q);
  assign wr_addr     = best_w[IdxW-1:0];

  // Shared compare unit: exact load compare with one extra bit.
  assign cur_cnt   = rd_valid_q ? rd_data_q : '0;
  assign cur_load  = LoadW'(cur_cnt) + LoadW'(rd_busy_q);
  assign best_load = LoadW'(best_cnt_q) + LoadW'(best_busy_q);
  assign take_cur  = (cmp_idx_q == '0) || (cur_load < best_load);

  assign new_cnt   = (best_cnt_q == CountMax) ? CountMax : best_cnt_q + COUNT_WIDTH'(1);
  assign new_total = (total_q == CountMax) ? CountMax : total_q + COUNT_WIDTH'(1);
  assign total_ext = TotExtW'(new_total);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lld_pkg::ST_IDLE: begin
        if (sched_acc) state_d = lld_pkg::ST_SCAN;
      end
      lld_pkg::ST_SCAN: begin
        if (last_cmp) state_d = lld_pkg::ST_UPDATE;
      end
      lld_pkg::ST_UPDATE: begin
        if (slot_free) state_d = lld_pkg::ST_IDLE;
      end
      default: state_d = lld_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    scan_active = 1'b0;
    upd_fire    = 1'b0;
    rd_idx      = '0;
    case (state_q)
      lld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lld_pkg::ST_SCAN: begin
        scan_active = 1'b1;
        rd_idx      = cmp_idx_q + ScanW'(1);
      end
      lld_pkg::ST_UPDATE: begin
        upd_fire = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmp_idx_d = cmp_idx_q;
    n_eff_d   = n_eff_q;
    no_pes_d  = no_pes_q;
    if (sched_acc) begin
      cmp_idx_d = '0;
      n_eff_d   = (n_sel == '0) ? ScanW'(1) : n_sel;
      no_pes_d  = (n_sel == '0);
    end else if (scan_active) begin
      cmp_idx_d = cmp_idx_q + ScanW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lld_pkg::ST_IDLE;
      pe_count_q  <= lld_pkg::PeCountReset;
      cmp_idx_q   <= '0;
      n_eff_q     <= ScanW'(1);
      no_pes_q    <= 1'b0;
      valid_q     <= '0;
      busy_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_idx_q <= cmp_idx_d;
      n_eff_q   <= n_eff_d;
      no_pes_q  <= no_pes_d;
      if (cfg_we_i) pe_count_q <= cfg_wdata_i;
      if (accept) begin
        case (in_i.action)
          lld_pkg::ACT_MARK_BUSY: begin
            if (id_in_range) busy_q[id_addr] <= (in_i.busy_until != '0);
          end
          lld_pkg::ACT_MARK_IDLE: begin
            if (id_in_range) busy_q[id_addr] <= 1'b0;
          end
          lld_pkg::ACT_CLEAR: begin
            valid_q <= '0;
            total_q <= '0;
          end
          default: ;
        endcase
      end
      if (upd_fire) begin
        valid_q[wr_addr] <= 1'b1;
        total_q          <= new_total;
        out_valid_q      <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count memory: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (upd_fire) mem[wr_addr] <= new_cnt;
    rd_data_q  <= mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
    rd_busy_q  <= busy_q[rd_addr];
  end

  // Best-so-far and result payload
  always_ff @(posedge clk_i) begin
    if (scan_active && take_cur) begin
      best_q      <= cmp_idx_q;
      best_cnt_q  <= cur_cnt;
      best_busy_q <= rd_busy_q;
    end
    if (upd_fire) begin
      out_sel_q    <= best_q[lld_pkg::PeIdWidth-1:0];
      out_no_pes_q <= no_pes_q;
      out_total_q  <= total_ext[lld_pkg::TotalWidth-1:0];
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.chosen_pe       = out_sel_q;
  assign out_o.no_pes          = out_no_pes_q;
  assign out_o.total_scheduled = out_total_q;

  // A new result only appears out of the update step.
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lld_pkg::ST_UPDATE))
    else $error("result raised outside update step");

  // The scan pointer stays inside the selected element range.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lld_pkg::ST_SCAN) |-> (cmp_idx_q < n_eff_q))
    else $error("scan index beyond element range");

  // Falling back on no elements reports element zero.
  a_no_pes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_no_pes_q) |-> (out_sel_q == '0))
    else $error("no_pes result with nonzero element");

  // The block is not ready at the start of a schedule that it has taken.
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sched_acc |=> !in_ready ##1 !in_ready)
    else $error("request taken during a schedule scan");

endmodule
